[hdl/tdp_pkg.sv]
// Shared types and constants for the trial division prime test unit.
`default_nettype none
package tdp_pkg;

	localparam int TDP_VALUE_BITS = 31;
	localparam int TDP_FIRST_DIVISOR = 3;
	localparam int TDP_DIVISOR_STEP = 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_TEST,
		ST_FINISH
	} tdp_state_t;

	typedef struct packed {
		logic load;
		logic start_div;
		logic advance;
		logic set_verdict;
		logic verdict;
		logic load_result;
	} tdp_cmd_t;

	typedef struct packed {
		logic below_two;
		logic even;
		logic is_two;
		logic square_over;
		logic div_done;
		logic rem_zero;
	} tdp_status_t;

endpackage
`default_nettype wire

[hdl/trial_division_prime_test_unit.sv]
// Top level of the trial division prime test unit.
// Usage:
//   A request on candidate/in_valid/in_ready carries one number. One result
//   on tested_value/is_prime/out_valid/out_ready follows for each request:
//   the number echoed back and 1 if it is prime, 0 otherwise.
//   Values below two and even values are settled in the first check step.
//   Odd values try the odd divisors from 3 upward while the divisor squared
//   does not exceed the value; each divisor is worked by the remainder unit,
//   which retires one dividend bit per cycle.
//   One request is worked at a time; the next is taken once the current
//   result sits in the output register, even while that result still waits.
//   A stalled receiver holds the result; a finished item then waits until
//   the output register frees.
//   Reset empties the output register and returns the sequencer to idle.
`default_nettype none
module trial_division_prime_test_unit
	import tdp_pkg::*;
#(
	parameter int VALUE_BITS = TDP_VALUE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [VALUE_BITS-1:0] candidate,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [VALUE_BITS-1:0]      tested_value,
	output logic                       is_prime
);

	tdp_cmd_t    cmd;
	tdp_status_t status;

	tdp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	tdp_datapath #(
		.VALUE_BITS(VALUE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.candidate   (candidate),
		.tested_value(tested_value),
		.is_prime    (is_prime)
	);

endmodule
`default_nettype wire

[hdl/tdp_rem_unit.sv]
// Restoring remainder unit, one dividend bit per cycle.
`default_nettype none
module tdp_rem_unit
	import tdp_pkg::*;
#(
	parameter int VALUE_BITS = TDP_VALUE_BITS,
	parameter int DIV_BITS = (VALUE_BITS + 1) / 2 + 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [VALUE_BITS-1:0] dividend,
	input  wire logic [DIV_BITS-1:0]   divisor,
	output logic                       done,
	output logic                       rem_zero
);

	localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

	logic [CNT_BITS-1:0]   count_q;
	logic [VALUE_BITS-1:0] shift_q;
	logic [DIV_BITS-1:0]   rem_q;
	logic [DIV_BITS:0]     shifted;
	logic [DIV_BITS:0]     diff;
	logic                  fits;

	assign shifted = {rem_q, shift_q[VALUE_BITS-1]};
	assign diff    = shifted - {1'b0, divisor};
	assign fits    = shifted >= {1'b0, divisor};
	assign done    = count_q == '0;
	assign rem_zero = rem_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (start) begin
			count_q <= CNT_BITS'(VALUE_BITS);
		end else if (!done) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
		end else if (!done) begin
			shift_q <= {shift_q[VALUE_BITS-2:0], 1'b0};
			rem_q   <= fits ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
		end
	end

endmodule
`default_nettype wire

[hdl/tdp_datapath.sv]
// Candidate, divisor, divisor square and result registers.
`default_nettype none
module tdp_datapath
	import tdp_pkg::*;
#(
	parameter int VALUE_BITS = TDP_VALUE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tdp_cmd_t              cmd,
	output tdp_status_t                status,
	input  wire logic [VALUE_BITS-1:0] candidate,
	output logic [VALUE_BITS-1:0]      tested_value,
	output logic                       is_prime
);

	localparam int DIV_BITS = (VALUE_BITS + 1) / 2 + 2;
	localparam int SQ_BITS = VALUE_BITS + 2;

	logic [VALUE_BITS-1:0] n_q;
	logic [DIV_BITS-1:0]   d_q;
	logic [SQ_BITS-1:0]    sq_q;
	logic                  verdict_q;
	logic                  div_done;
	logic                  rem_zero;

	tdp_rem_unit #(
		.VALUE_BITS(VALUE_BITS),
		.DIV_BITS  (DIV_BITS)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.start_div),
		.dividend(n_q),
		.divisor (d_q),
		.done    (div_done),
		.rem_zero(rem_zero)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q  <= candidate;
			d_q  <= DIV_BITS'(TDP_FIRST_DIVISOR);
			sq_q <= SQ_BITS'(TDP_FIRST_DIVISOR * TDP_FIRST_DIVISOR);
		end else if (cmd.advance) begin
			d_q  <= d_q + DIV_BITS'(TDP_DIVISOR_STEP);
			sq_q <= sq_q + SQ_BITS'({d_q, 2'b00})
				+ SQ_BITS'(TDP_DIVISOR_STEP * TDP_DIVISOR_STEP);
		end
		if (cmd.set_verdict) begin
			verdict_q <= cmd.verdict;
		end
		if (cmd.load_result) begin
			tested_value <= n_q;
			is_prime     <= verdict_q;
		end
	end

	always_comb begin
		status.below_two   = n_q[VALUE_BITS-1:1] == '0;
		status.even        = ~n_q[0];
		status.is_two      = n_q == VALUE_BITS'(2);
		status.square_over = sq_q > SQ_BITS'(n_q);
		status.div_done    = div_done;
		status.rem_zero    = rem_zero;
	end

endmodule
`default_nettype wire

[hdl/tdp_ctrl.sv]
// Sequencer for the trial division loop and the output handshake.
`default_nettype none
module tdp_ctrl
	import tdp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire tdp_status_t status,
	output tdp_cmd_t         cmd
);

	tdp_state_t state_q;
	tdp_state_t state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.below_two) begin
					cmd.set_verdict = 1'b1;
					state_d         = ST_FINISH;
				end else if (status.even) begin
					cmd.set_verdict = 1'b1;
					cmd.verdict     = status.is_two;
					state_d         = ST_FINISH;
				end else if (status.square_over) begin
					cmd.set_verdict = 1'b1;
					cmd.verdict     = 1'b1;
					state_d         = ST_FINISH;
				end else begin
					cmd.start_div = 1'b1;
					state_d       = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (status.div_done) begin
					state_d = ST_TEST;
				end
			end
			ST_TEST: begin
				if (status.rem_zero) begin
					cmd.set_verdict = 1'b1;
					state_d         = ST_FINISH;
				end else begin
					cmd.advance = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_load_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |-> slot_free)
		else $error("result loaded over an untaken result");
	a_load_shows_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |=> out_valid_q)
		else $error("loaded result not presented");
	a_accept_checks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_CHECK))
		else $error("accepted request did not enter check");
	a_divide_started: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_div |=> (state_q == ST_DIVIDE && !status.div_done))
		else $error("remainder unit not busy after start");
`endif

endmodule
`default_nettype wire
